/* rtl/assert_macros.svh */
// Assertion macros for the allocator RTL.
// Define ASSERT_OFF to compile the checks out; depends on clk and arst_n in the user scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/ptba_pkg.sv */
// Package for the per-thread bump allocator: widths, codes, beat and record types, helpers.
// No dependencies; used by every RTL module of the block.
package ptba_pkg;

	localparam int ADDR_WIDTH      = 32;
	localparam int DEF_MAX_THREADS = 8;

	localparam int SIZE_W     = 24;
	localparam int TIDIN_W    = 3;
	localparam int CHUNK_W    = 21;
	localparam int TCNT_W     = 4;
	localparam int LEN_W      = 25;
	localparam int CNT_W      = 64;
	localparam int GROW_W     = 32;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int ALLOC_ALIGN = 4;
	localparam int SYS_ALIGN   = 4096;

	localparam logic REQ_INIT  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	localparam logic [1:0] KIND_BUMP = 2'd0;
	localparam logic [1:0] KIND_NEXT = 2'd1;
	localparam logic [1:0] KIND_GROW = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_HEAP_BASE    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEAP_LIMIT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THREAD_COUNT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_CHUNK_BYTES  = 2'd3;

	localparam logic [ADDR_WIDTH-1:0] RST_HEAP_BASE    = 32'h0000_0000;
	localparam logic [ADDR_WIDTH-1:0] RST_HEAP_LIMIT   = 32'hFFFF_FFFF;
	localparam logic [TCNT_W-1:0]     RST_THREAD_COUNT = 4'd1;
	localparam logic [CHUNK_W-1:0]    RST_CHUNK_BYTES  = 21'd8192;

	typedef struct packed {
		logic               req_type;
		logic [TIDIN_W-1:0] thread_id;
		logic [SIZE_W-1:0]  req_size;
	} req_t;

	typedef struct packed {
		logic [ADDR_WIDTH-1:0] alloc_addr;
		logic                  ok;
		logic [1:0]            refill_kind;
		logic [CNT_W-1:0]      thread_used_bytes;
		logic [CNT_W-1:0]      thread_sys_bytes;
		logic [CNT_W-1:0]      total_heap_bytes;
		logic [GROW_W-1:0]     growth_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_WIDTH-1:0] heap_base;
		logic [ADDR_WIDTH-1:0] heap_limit;
		logic [TCNT_W-1:0]     thread_count;
		logic [CHUNK_W-1:0]    chunk_bytes;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_WIDTH-1:0] cur_base;
		logic [LEN_W-1:0]      cur_length;
		logic [LEN_W-1:0]      cur_offset;
		logic [ADDR_WIDTH-1:0] next_base;
		logic [LEN_W-1:0]      next_length;
		logic [CNT_W-1:0]      used_bytes;
		logic [CNT_W-1:0]      granted_bytes;
	} thread_rec_t;

	function automatic logic [LEN_W-1:0] round_alloc(input logic [SIZE_W-1:0] size);
		logic [LEN_W-1:0] s;
		s = LEN_W'(size) + LEN_W'(ALLOC_ALIGN - 1);
		return s & ~LEN_W'(ALLOC_ALIGN - 1);
	endfunction

	// top + amount stays within limit
	function automatic logic fits(input logic [ADDR_WIDTH-1:0] top,
		input logic [ADDR_WIDTH-1:0] amount, input logic [ADDR_WIDTH-1:0] limit);
		return (top <= limit) && (amount <= (limit - top));
	endfunction

endpackage

/* rtl/per_thread_bump_allocator_core.sv */
// Per-thread bump allocator. An allocation that fits the thread's current interval, or that
// switches to its prepared next interval, goes through a check state to the result state,
// which offers the result and returns to idle once it is taken. Init and heap growth sweep
// the N threads in use, writing the per-thread memory one entry per cycle through its write
// port; growth also reads each entry through the registered read port. A failing request (not
// initialised, thread out of range), an init past the limit and a failed growth go to the
// result state with no sweep. The next request is taken while a result still waits in the
// output register. next_valid lives in flip-flops, so no clearing pass is needed after reset.
module per_thread_bump_allocator_core #(
	parameter int MAX_THREADS = ptba_pkg::DEF_MAX_THREADS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptba_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [ptba_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  ptba_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output ptba_pkg::rsp_t                    rsp
);
	import ptba_pkg::*;

	localparam int TID_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

	cfg_t              cfg_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	rsp_t              res;
	logic              res_valid;
	logic              res_ready;
	logic              mem_we;
	logic [TID_W-1:0]  mem_waddr;
	thread_rec_t       mem_wdata;
	logic              mem_re;
	logic [TID_W-1:0]  mem_raddr;
	thread_rec_t       mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{heap_base: RST_HEAP_BASE, heap_limit: RST_HEAP_LIMIT,
				thread_count: RST_THREAD_COUNT, chunk_bytes: RST_CHUNK_BYTES};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEAP_BASE:    cfg_q.heap_base    <= cfg_data[ADDR_WIDTH-1:0];
				REG_HEAP_LIMIT:   cfg_q.heap_limit   <= cfg_data[ADDR_WIDTH-1:0];
				REG_THREAD_COUNT: cfg_q.thread_count <= cfg_data[TCNT_W-1:0];
				REG_CHUNK_BYTES:  cfg_q.chunk_bytes  <= cfg_data[CHUNK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ptba_ctrl #(
		.MAX_THREADS(MAX_THREADS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ptba_thread_mem #(
		.DEPTH(MAX_THREADS),
		.AW   (TID_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output beat register
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_mem_no_rw_clash, !(mem_we && mem_re && (mem_waddr == mem_raddr)), "memory read and write hit one entry")
	`ASSERT_ALWAYS(a_no_res_while_idle, !(res_valid && req_ready), "result offered while taking requests")
	`ASSERT_ALWAYS(a_no_write_while_idle, !(mem_we && req_ready), "memory written while idle")
	`ASSERT_NEXT(a_res_loads_out, res_valid && res_ready, rsp_valid, "finished result not presented")

endmodule

/* rtl/ptba_thread_mem.sv */
// Per-thread interval and counter store: one write port, one registered read port.
// Depends on ptba_pkg for the record type.
module ptba_thread_mem #(
	parameter int DEPTH = ptba_pkg::DEF_MAX_THREADS,
	parameter int AW    = 3
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  ptba_pkg::thread_rec_t wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output ptba_pkg::thread_rec_t rdata
);
	import ptba_pkg::*;

	thread_rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/ptba_ctrl.sv */
// Request sequencer of the bump allocator: init sweep, bump check, heap growth sweep.
// Depends on ptba_pkg; drives the ports of ptba_thread_mem.
module ptba_ctrl #(
	parameter int MAX_THREADS = ptba_pkg::DEF_MAX_THREADS,
	localparam int TID_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptba_pkg::cfg_t        cfg,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  ptba_pkg::req_t        req,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ptba_pkg::rsp_t        res,
	output logic                  mem_we,
	output logic [TID_W-1:0]      mem_waddr,
	output ptba_pkg::thread_rec_t mem_wdata,
	output logic                  mem_re,
	output logic [TID_W-1:0]      mem_raddr,
	input  ptba_pkg::thread_rec_t mem_rdata
);
	import ptba_pkg::*;

	localparam int CW       = ((TID_W > TCNT_W) ? TID_W : TCNT_W) + 1;
	localparam int REGION_W = CHUNK_W + $clog2(MAX_THREADS + 1) + 1;
	localparam int TOTAL_W  = LEN_W + TCNT_W + 1;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_INIT_CHK = 8'b0000_0010,
		S_INIT_WR  = 8'b0000_0100,
		S_CHK      = 8'b0000_1000,
		S_GROW_MUL = 8'b0001_0000,
		S_GROW_CHK = 8'b0010_0000,
		S_GROW     = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic                   initialised_q;
	logic [MAX_THREADS-1:0] next_valid_q;
	logic [ADDR_WIDTH-1:0]  heap_top_q;
	logic [CNT_W-1:0]       heap_bytes_q;
	logic [GROW_W-1:0]      growths_q;

	logic [SIZE_W-1:0]      size_q;
	logic [TID_W-1:0]       tidx_q;
	logic [TCNT_W-1:0]      n_q;
	logic                   tvalid_q;
	logic [LEN_W-1:0]       asz_q;
	logic [REGION_W-1:0]    region_q;
	logic [LEN_W-1:0]       per_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [TID_W-1:0]       idx_q;
	logic [ADDR_WIDTH-1:0]  run_base_q;
	logic [CNT_W-1:0]       hold_used_q;
	logic [CNT_W-1:0]       hold_granted_q;
	rsp_t                   res_q;

	logic [TCNT_W-1:0]      n_cur;
	logic                   tvalid_cur;
	logic [REGION_W-1:0]    region_prod;
	logic [REGION_W-1:0]    region_cur;
	logic [TOTAL_W-1:0]     total_prod;
	logic [TOTAL_W-1:0]     total_cur;
	logic                   last;
	logic                   is_req;
	logic                   fit_cur;
	logic                   nxt_ok;
	logic                   fit_init;
	logic                   fit_grow;
	logic [CNT_W-1:0]       new_used;
	logic [CNT_W-1:0]       new_granted;
	thread_rec_t            rd;

	assign rd = mem_rdata;

	always_comb begin
		if (cfg.thread_count == '0) begin
			n_cur = TCNT_W'(1);
		end else if (int'(cfg.thread_count) > MAX_THREADS) begin
			n_cur = TCNT_W'(MAX_THREADS);
		end else begin
			n_cur = cfg.thread_count;
		end
	end

	assign tvalid_cur  = TCNT_W'(req.thread_id) < n_cur;
	assign region_prod = REGION_W'(cfg.chunk_bytes) * REGION_W'(MAX_THREADS);
	assign region_cur  = (region_prod + REGION_W'(SYS_ALIGN - 1)) & ~REGION_W'(SYS_ALIGN - 1);
	assign total_prod  = TOTAL_W'(per_q) * TOTAL_W'(n_q);
	assign total_cur   = (total_prod + TOTAL_W'(SYS_ALIGN - 1)) & ~TOTAL_W'(SYS_ALIGN - 1);

	assign last        = (CW'(idx_q) + CW'(1)) == CW'(n_q);
	assign is_req      = idx_q == tidx_q;
	assign fit_cur     = ({1'b0, rd.cur_offset} + {1'b0, asz_q}) <= {1'b0, rd.cur_length};
	assign nxt_ok      = next_valid_q[tidx_q] && (rd.next_length >= asz_q);
	assign fit_init    = fits(cfg.heap_base, ADDR_WIDTH'(region_q), cfg.heap_limit);
	assign fit_grow    = fits(heap_top_q, ADDR_WIDTH'(total_q), cfg.heap_limit);
	assign new_used    = rd.used_bytes + CNT_W'(size_q);
	assign new_granted = rd.granted_bytes + CNT_W'(per_q);

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd;
		case (state_q)
			S_IDLE: begin
				mem_re    = req_valid;
				mem_raddr = TID_W'(req.thread_id);
			end
			S_INIT_WR: begin
				mem_we                  = 1'b1;
				mem_wdata.cur_base      = run_base_q;
				mem_wdata.cur_length    = LEN_W'(cfg.chunk_bytes);
				mem_wdata.cur_offset    = '0;
				mem_wdata.next_base     = '0;
				mem_wdata.next_length   = '0;
				mem_wdata.used_bytes    = '0;
				mem_wdata.granted_bytes = CNT_W'(cfg.chunk_bytes);
			end
			S_CHK: begin
				mem_waddr = tidx_q;
				if (fit_cur) begin
					mem_we               = 1'b1;
					mem_wdata.cur_offset = rd.cur_offset + asz_q;
					mem_wdata.used_bytes = new_used;
				end else if (nxt_ok) begin
					mem_we                = 1'b1;
					mem_wdata.cur_base    = rd.next_base;
					mem_wdata.cur_length  = rd.next_length;
					mem_wdata.cur_offset  = asz_q;
					mem_wdata.next_base   = '0;
					mem_wdata.next_length = '0;
					mem_wdata.used_bytes  = new_used;
				end
			end
			S_GROW_CHK: begin
				mem_re = fit_grow;
			end
			S_GROW: begin
				mem_we                  = 1'b1;
				mem_wdata.granted_bytes = new_granted;
				if (is_req) begin
					mem_wdata.cur_base    = run_base_q;
					mem_wdata.cur_length  = per_q;
					mem_wdata.cur_offset  = asz_q;
					mem_wdata.next_base   = '0;
					mem_wdata.next_length = '0;
					mem_wdata.used_bytes  = new_used;
				end else begin
					mem_wdata.next_base   = run_base_q;
					mem_wdata.next_length = per_q;
				end
				mem_re    = !last;
				mem_raddr = idx_q + TID_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			initialised_q <= 1'b0;
			next_valid_q  <= '0;
			heap_top_q    <= '0;
			heap_bytes_q  <= '0;
			growths_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.req_type == REQ_INIT) begin
							state_q <= S_INIT_CHK;
						end else if (initialised_q && tvalid_cur) begin
							state_q <= S_CHK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_INIT_CHK: begin
					if (fit_init) begin
						state_q <= S_INIT_WR;
					end else begin
						initialised_q <= 1'b0;
						state_q       <= S_DONE;
					end
				end
				S_INIT_WR: begin
					if (last) begin
						heap_top_q    <= cfg.heap_base + ADDR_WIDTH'(region_q);
						heap_bytes_q  <= CNT_W'(region_q);
						growths_q     <= GROW_W'(1);
						initialised_q <= 1'b1;
						next_valid_q  <= '0;
						state_q       <= S_DONE;
					end
				end
				S_CHK: begin
					if (fit_cur) begin
						state_q <= S_DONE;
					end else if (nxt_ok) begin
						next_valid_q[tidx_q] <= 1'b0;
						state_q              <= S_DONE;
					end else begin
						growths_q <= growths_q + GROW_W'(1);
						state_q   <= S_GROW_MUL;
					end
				end
				S_GROW_MUL: begin
					state_q <= S_GROW_CHK;
				end
				S_GROW_CHK: begin
					if (fit_grow) begin
						heap_top_q   <= heap_top_q + ADDR_WIDTH'(total_q);
						heap_bytes_q <= heap_bytes_q + CNT_W'(total_q);
						state_q      <= S_GROW;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_GROW: begin
					next_valid_q[idx_q] <= !is_req;
					if (last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					size_q   <= req.req_size;
					tidx_q   <= TID_W'(req.thread_id);
					n_q      <= n_cur;
					tvalid_q <= tvalid_cur;
					asz_q    <= round_alloc(req.req_size);
					region_q <= region_cur;
					res_q    <= '{alloc_addr: '0, ok: 1'b0, refill_kind: KIND_BUMP,
						thread_used_bytes: '0, thread_sys_bytes: '0,
						total_heap_bytes: heap_bytes_q, growth_count: growths_q};
				end
			end
			S_INIT_CHK: begin
				idx_q      <= '0;
				run_base_q <= cfg.heap_base;
			end
			S_INIT_WR: begin
				idx_q      <= idx_q + TID_W'(1);
				run_base_q <= run_base_q + ADDR_WIDTH'(cfg.chunk_bytes);
				if (last) begin
					res_q.alloc_addr        <= cfg.heap_base;
					res_q.ok                <= 1'b1;
					res_q.refill_kind       <= KIND_BUMP;
					res_q.thread_used_bytes <= '0;
					res_q.thread_sys_bytes  <= tvalid_q ? CNT_W'(cfg.chunk_bytes) : '0;
					res_q.total_heap_bytes  <= CNT_W'(region_q);
					res_q.growth_count      <= GROW_W'(1);
				end
			end
			S_CHK: begin
				hold_used_q             <= rd.used_bytes;
				hold_granted_q          <= rd.granted_bytes;
				per_q                   <= (LEN_W'(cfg.chunk_bytes) > asz_q) ?
					LEN_W'(cfg.chunk_bytes) : asz_q;
				res_q.ok                <= 1'b1;
				res_q.thread_used_bytes <= new_used;
				res_q.thread_sys_bytes  <= rd.granted_bytes;
				if (fit_cur) begin
					res_q.alloc_addr  <= rd.cur_base + ADDR_WIDTH'(rd.cur_offset);
					res_q.refill_kind <= KIND_BUMP;
				end else begin
					res_q.alloc_addr  <= rd.next_base;
					res_q.refill_kind <= KIND_NEXT;
				end
			end
			S_GROW_MUL: begin
				total_q <= total_cur;
			end
			S_GROW_CHK: begin
				idx_q              <= '0;
				run_base_q         <= heap_top_q;
				res_q.refill_kind  <= KIND_GROW;
				res_q.growth_count <= growths_q;
				if (fit_grow) begin
					res_q.ok               <= 1'b1;
					res_q.total_heap_bytes <= heap_bytes_q + CNT_W'(total_q);
				end else begin
					res_q.alloc_addr        <= '0;
					res_q.ok                <= 1'b0;
					res_q.thread_used_bytes <= hold_used_q;
					res_q.thread_sys_bytes  <= hold_granted_q;
					res_q.total_heap_bytes  <= heap_bytes_q;
				end
			end
			S_GROW: begin
				idx_q      <= idx_q + TID_W'(1);
				run_base_q <= run_base_q + ADDR_WIDTH'(per_q);
				if (is_req) begin
					res_q.alloc_addr        <= run_base_q;
					res_q.thread_used_bytes <= new_used;
					res_q.thread_sys_bytes  <= new_granted;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* dv/alloc_checker.sv */
// Checker for the per-thread bump allocator: tracks config writes, predicts each response
// from its own model of the heap and thread intervals, and compares it field by field.
// Depends on ptba_pkg for the beat types and register codes.
module alloc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ptba_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [ptba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  ptba_pkg::req_t                  req,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  ptba_pkg::rsp_t                  rsp,
	output int                              pending,
	output int                              errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import ptba_pkg::*;

	localparam int MAXT = DEF_MAX_THREADS;

	logic [63:0] base_reg, limit_reg, chunk_reg;
	logic [3:0]  threads_reg;
	logic [63:0] heap_top, heap_total;
	logic [31:0] grow_cnt;
	bit          armed;
	logic [63:0] cur_base [MAXT];
	logic [63:0] cur_len [MAXT];
	logic [63:0] cur_off [MAXT];
	logic [63:0] nxt_base [MAXT];
	logic [63:0] nxt_len [MAXT];
	logic [63:0] used [MAXT];
	logic [63:0] granted [MAXT];
	bit          nxt_ok [MAXT];
	rsp_t        grant_q [$];
	int          err_cnt = 0;

	assign errors = err_cnt;

	function automatic logic [63:0] align_up(input logic [63:0] x, input logic [63:0] a);
		return (x + a - 64'd1) & ~(a - 64'd1);
	endfunction

	function automatic bit room(input logic [63:0] top, input logic [63:0] amount);
		return (top <= limit_reg) && (amount <= limit_reg - top);
	endfunction

	function automatic rsp_t report(input logic [63:0] addr, input logic ok,
		input logic [1:0] kind, input int t, input bit tv);
		rsp_t o;
		o.alloc_addr        = addr[ADDR_WIDTH-1:0];
		o.ok                = ok;
		o.refill_kind       = kind;
		o.thread_used_bytes = tv ? used[t] : '0;
		o.thread_sys_bytes  = tv ? granted[t] : '0;
		o.total_heap_bytes  = heap_total;
		o.growth_count      = grow_cnt;
		return o;
	endfunction

	function automatic rsp_t serve(input req_t r);
		logic [63:0] n, asz, per, total, region, addr;
		logic [1:0]  kind;
		bit          tv;
		int          t;
		t = r.thread_id;
		n = (threads_reg == 0) ? 64'd1 : (threads_reg > MAXT) ? 64'(MAXT) : 64'(threads_reg);
		tv = t < n;
		if (r.req_type == REQ_INIT) begin
			region = align_up(chunk_reg * MAXT, 64'(SYS_ALIGN));
			if (!room(base_reg, region)) begin
				armed = 0;
				return report('0, 1'b0, KIND_BUMP, t, 0);
			end
			heap_top = base_reg + region;
			for (int i = 0; i < MAXT; i++)
				nxt_ok[i] = 0;
			for (int i = 0; i < n; i++) begin
				cur_base[i] = base_reg + i * chunk_reg;
				cur_len[i]  = chunk_reg;
				cur_off[i]  = '0;
				nxt_base[i] = '0;
				nxt_len[i]  = '0;
				used[i]     = '0;
				granted[i]  = chunk_reg;
			end
			heap_total = region;
			grow_cnt = 32'd1;
			armed = 1;
			return report(base_reg, 1'b1, KIND_BUMP, t, tv);
		end
		if (!armed || !tv)
			return report('0, 1'b0, KIND_BUMP, t, 0);
		asz = align_up(64'(r.req_size), 64'(ALLOC_ALIGN));
		kind = KIND_BUMP;
		if (cur_off[t] + asz > cur_len[t]) begin
			if (!(nxt_ok[t] && nxt_len[t] >= asz)) begin
				per = (chunk_reg > asz) ? chunk_reg : asz;
				total = align_up(per * n, 64'(SYS_ALIGN));
				grow_cnt = grow_cnt + 32'd1;
				if (!room(heap_top, total))
					return report('0, 1'b0, KIND_GROW, t, 1);
				for (int i = 0; i < n; i++) begin
					nxt_base[i] = heap_top + i * per;
					nxt_len[i]  = per;
					nxt_ok[i]   = 1;
					granted[i]  = granted[i] + per;
				end
				heap_top = heap_top + total;
				heap_total = heap_total + total;
				kind = KIND_GROW;
			end else begin
				kind = KIND_NEXT;
			end
			cur_base[t] = nxt_base[t];
			cur_len[t]  = nxt_len[t];
			cur_off[t]  = '0;
			nxt_base[t] = '0;
			nxt_len[t]  = '0;
			nxt_ok[t]   = 0;
		end
		addr = cur_base[t] + cur_off[t];
		cur_off[t] = cur_off[t] + asz;
		used[t] = used[t] + 64'(r.req_size);
		return report(addr, 1'b1, kind, t, 1);
	endfunction

	task automatic check_grant(input rsp_t got, input rsp_t want);
		if (got.alloc_addr !== want.alloc_addr) begin
			$error("alloc_addr: expected %h, got %h", want.alloc_addr, got.alloc_addr);
			err_cnt++;
		end
		if (got.ok !== want.ok) begin
			$error("ok: expected %b, got %b", want.ok, got.ok);
			err_cnt++;
		end
		if (got.refill_kind !== want.refill_kind) begin
			$error("refill_kind: expected %0d, got %0d", want.refill_kind, got.refill_kind);
			err_cnt++;
		end
		if (got.thread_used_bytes !== want.thread_used_bytes) begin
			$error("thread_used_bytes: expected %h, got %h",
				want.thread_used_bytes, got.thread_used_bytes);
			err_cnt++;
		end
		if (got.thread_sys_bytes !== want.thread_sys_bytes) begin
			$error("thread_sys_bytes: expected %h, got %h",
				want.thread_sys_bytes, got.thread_sys_bytes);
			err_cnt++;
		end
		if (got.total_heap_bytes !== want.total_heap_bytes) begin
			$error("total_heap_bytes: expected %h, got %h",
				want.total_heap_bytes, got.total_heap_bytes);
			err_cnt++;
		end
		if (got.growth_count !== want.growth_count) begin
			$error("growth_count: expected %h, got %h", want.growth_count, got.growth_count);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg    = 64'(RST_HEAP_BASE);
			limit_reg   = 64'(RST_HEAP_LIMIT);
			threads_reg = RST_THREAD_COUNT;
			chunk_reg   = 64'(RST_CHUNK_BYTES);
			heap_top    = '0;
			heap_total  = '0;
			grow_cnt    = '0;
			armed       = 0;
			for (int i = 0; i < MAXT; i++) begin
				cur_base[i] = '0;
				cur_len[i]  = '0;
				cur_off[i]  = '0;
				nxt_base[i] = '0;
				nxt_len[i]  = '0;
				used[i]     = '0;
				granted[i]  = '0;
				nxt_ok[i]   = 0;
			end
			grant_q.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (grant_q.size() == 0) begin
					$error("response beat with no request outstanding");
					err_cnt++;
				end else begin
					check_grant(rsp, grant_q.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HEAP_BASE:    base_reg = 64'(cfg_data);
					REG_HEAP_LIMIT:   limit_reg = 64'(cfg_data);
					REG_THREAD_COUNT: threads_reg = cfg_data[TCNT_W-1:0];
					REG_CHUNK_BYTES:  chunk_reg = 64'(cfg_data[CHUNK_W-1:0]);
					default: begin
					end
				endcase
			end
			if (req_valid && req_ready)
				grant_q.push_back(serve(req));
			pending <= grant_q.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// Top of the allocator testbench: clock, reset, config writes, request and response pacing.
// Instantiates per_thread_bump_allocator_core and alloc_checker; needs ptba_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ptba_pkg::*;

	localparam int LIMIT         = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 90;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	int                    pending;
	int                    errors;
	int                    cycles = 0;
	int                    gap_pct = 0;
	int                    stall_pct = 0;
	logic [3:0]            thr_cfg = RST_THREAD_COUNT;
	logic [31:0]           chunk_cfg = 32'(RST_CHUNK_BYTES);

	per_thread_bump_allocator_core dut (.*);
	alloc_checker chk (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk)
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic req_t mk(input logic typ, input int tid, input int size);
		req_t r;
		r.req_type  = typ;
		r.thread_id = TIDIN_W'(tid);
		r.req_size  = SIZE_W'(size);
		return r;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   n, p;
		n = (thr_cfg == 0) ? 1 : (thr_cfg > DEF_MAX_THREADS) ? DEF_MAX_THREADS : thr_cfg;
		r.req_type = ($urandom_range(0, 99) < 3) ? REQ_INIT : REQ_ALLOC;
		r.thread_id = TIDIN_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1)
			: $urandom_range(0, 7));
		p = $urandom_range(0, 99);
		if (p < 10)
			r.req_size = SIZE_W'($urandom_range(0, 15));
		else if (p < 80)
			r.req_size = SIZE_W'($urandom_range(0, chunk_cfg + chunk_cfg / 4));
		else if (p < 95)
			r.req_size = SIZE_W'($urandom_range(0, 4 * chunk_cfg));
		else
			r.req_size = SIZE_W'($urandom);
		return r;
	endfunction

	task automatic drain();
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// caller has already dropped req_valid
	task automatic configure(input logic [31:0] base, input logic [31:0] limit,
		input logic [3:0] thr, input logic [31:0] chunk);
		drain();
		set_reg(REG_HEAP_BASE, base);
		set_reg(REG_HEAP_LIMIT, limit);
		set_reg(REG_THREAD_COUNT, 32'(thr));
		set_reg(REG_CHUNK_BYTES, chunk);
		cfg_valid <= 1'b0;
		thr_cfg = thr;
		chunk_cfg = chunk;
	endtask

	task automatic send(input req_t r, input bit hold);
		int g;
		g = 0;
		while ($urandom_range(0, 99) < gap_pct)
			g++;
		if (hold || g > 0) begin
			req_valid <= 1'b0;
			if (hold)
				drain();
			else
				repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	initial begin
		logic [31:0] base, limit, chunk;
		logic [3:0]  thr;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: alloc before init, out-of-range thread, rounding, growth
		send(mk(REQ_ALLOC, 0, 5), 0);
		send(mk(REQ_INIT, 0, 0), 0);
		send(mk(REQ_ALLOC, 1, 8), 0);
		send(mk(REQ_ALLOC, 0, 0), 0);
		send(mk(REQ_ALLOC, 0, 1), 0);
		send(mk(REQ_ALLOC, 0, 3), 0);
		send(mk(REQ_ALLOC, 0, 4), 0);
		send(mk(REQ_ALLOC, 0, 24'hFFFFFF), 0);
		send(mk(REQ_ALLOC, 0, 8192), 0);

		// tight heap: next-interval switch, growth up to the limit, then failed growth
		req_valid <= 1'b0;
		configure(32'h0000_1000, 32'h0000_4000, 4'd8, 32'd64);
		send(mk(REQ_INIT, 7, 0), 0);
		send(mk(REQ_ALLOC, 7, 64), 0);
		send(mk(REQ_ALLOC, 7, 1), 0);
		send(mk(REQ_ALLOC, 0, 64), 1);
		send(mk(REQ_ALLOC, 0, 4), 0);
		send(mk(REQ_ALLOC, 3, 256), 0);
		send(mk(REQ_ALLOC, 5, 512), 0);
		send(mk(REQ_ALLOC, 6, 0), 0);

		// init past the limit
		req_valid <= 1'b0;
		configure(32'hFFFF_F000, 32'hFFFF_FFFF, 4'd8, 32'd64);
		send(mk(REQ_INIT, 0, 0), 0);
		send(mk(REQ_ALLOC, 0, 4), 0);
		req_valid <= 1'b0;
		configure(32'h0, 32'h0, 4'd8, 32'd64);
		send(mk(REQ_INIT, 2, 0), 0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			req_valid <= 1'b0;
			case (p)
				0: begin
					base = 32'h0; limit = 32'hFFFF_FFFF; thr = 4'd8; chunk = 32'd64;
				end
				1: begin
					base = $urandom_range(0, 32'h3FFF_FFFF); limit = 32'hFFFF_FFFF;
					thr = 4'd3; chunk = 32'd1000;
				end
				2: begin
					base = 32'h0001_0000; limit = 32'h0001_8000; thr = 4'd4; chunk = 32'd256;
				end
				3: begin
					base = 32'h100; limit = 32'hFFFF_FFFF; thr = 4'd0; chunk = 32'd4;
				end
				4: begin
					base = 32'h0; limit = 32'hFFFF_FFFF; thr = 4'd15; chunk = 32'd1048576;
				end
				5: begin
					base = $urandom_range(0, 32'h7FFF_FFFF); limit = base + 32'h0400_0000;
					thr = 4'd5; chunk = 32'd8192;
				end
				6: begin
					base = 32'h8000_0000; limit = 32'h8010_0000; thr = 4'd7; chunk = 32'd100;
				end
				default: begin
					base = $urandom_range(0, 32'hF000_0000);
					limit = base + $urandom_range(0, 32'h0FFF_FFFF);
					thr = 4'($urandom_range(0, 15)); chunk = $urandom_range(4, 1048576);
				end
			endcase
			configure(base, limit, thr, chunk);
			gap_pct = (p % 4 == 1) ? 57 : (p % 4 == 3) ? 9 : 0;
			stall_pct = (p % 4 == 2) ? 57 : (p % 4 == 3) ? 9 : 0;
			send(mk(REQ_INIT, 0, 0), 0);
			repeat (PHASE_ITEMS)
				send(rand_req(), $urandom_range(0, 49) == 0);
		end

		req_valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
